>>> hdl/tgs_pkg.sv
// ----------------------------------------------------------------------------
// tgs_pkg
// Shared widths, codes and types of the trilinear grid sampler.
// ----------------------------------------------------------------------------
package tgs_pkg;

	localparam int unsigned TGS_XRES   = 32;
	localparam int unsigned TGS_YRES   = 32;
	localparam int unsigned TGS_ZRES   = 32;

	localparam int unsigned GRID_DEPTH = 32768;
	localparam int unsigned ADDR_W     = $clog2(GRID_DEPTH);

	localparam int unsigned VAL_W      = 32;
	localparam int unsigned INV_W      = 31;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned DIFF_W     = 33;
	localparam int unsigned MULB_W     = 32;
	localparam int unsigned PROD_W     = DIFF_W + MULB_W;
	localparam int unsigned ACC_W      = PROD_W + 1;
	localparam int unsigned COORD_W    = 30;
	localparam int unsigned WGT_W      = 31;
	localparam int unsigned CIDX_W     = 14;
	localparam int unsigned FRAC_W     = 16;

	localparam logic signed [COORD_W-1:0] COORD_LIMIT = 30'sd268435456;
	localparam logic [WGT_W-1:0]          WGT_ONE     = 31'd65536;
	localparam logic [ACC_W-1:0]          ROUND_HALF  = 66'd32768;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_DX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_DY   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INV_DZ   = 3'd5;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [VAL_W-1:0]  wdata;
	} mem_req_t;

endpackage

>>> hdl/tgs_if.sv
// ----------------------------------------------------------------------------
// tgs_req_if / tgs_rsp_if
// Valid/ready channels of the sampler: request words in, sample words out.
// ----------------------------------------------------------------------------
interface tgs_req_if;
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic [tgs_pkg::ADDR_W-1:0]          cell_index;
	logic signed [tgs_pkg::VAL_W-1:0]    cell_value;
	logic signed [tgs_pkg::VAL_W-1:0]    pos_x;
	logic signed [tgs_pkg::VAL_W-1:0]    pos_y;
	logic signed [tgs_pkg::VAL_W-1:0]    pos_z;

	modport source (output valid, op, cell_index, cell_value, pos_x, pos_y, pos_z,
		input ready);
	modport sink (input valid, op, cell_index, cell_value, pos_x, pos_y, pos_z,
		output ready);
endinterface

interface tgs_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [tgs_pkg::VAL_W-1:0]    sample_value;
	logic                                saturated;

	modport source (output valid, sample_value, saturated, input ready);
	modport sink (input valid, sample_value, saturated, output ready);
endinterface

>>> hdl/tgs_mem.sv
// ----------------------------------------------------------------------------
// tgs_mem
// Single-port grid store: one registered read per cycle, plus one write when we is set.
// ----------------------------------------------------------------------------
module tgs_mem (
	input  logic                        clk,
	input  tgs_pkg::mem_req_t           mreq,
	output logic [tgs_pkg::VAL_W-1:0]   rdata
);
	import tgs_pkg::*;

	logic [VAL_W-1:0] cells_q [GRID_DEPTH];
	logic [VAL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			cells_q[mreq.addr] <= mreq.wdata;
		end
		rdata_q <= cells_q[mreq.addr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/tgs_mul.sv
// ----------------------------------------------------------------------------
// tgs_mul
// Shared signed multiplier with its product registered.
// ----------------------------------------------------------------------------
module tgs_mul (
	input  logic                                 clk,
	input  logic signed [tgs_pkg::DIFF_W-1:0]    a,
	input  logic signed [tgs_pkg::MULB_W-1:0]    b,
	output logic signed [tgs_pkg::PROD_W-1:0]    prod
);
	import tgs_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(a) * PROD_W'(b);
	end

	assign prod = prod_s1;

endmodule

>>> hdl/trilinear_grid_sampler.sv
// ----------------------------------------------------------------------------
// trilinear_grid_sampler
// Grid store with a trilinear sampler built on one shared multiplier.
//
// Request channel (req): a write word (op = write) stores cell_value at
// cell_index; writes may follow each other every cycle and
// give no result. A sample word (op = sample) gives one result word on rsp.
// A sample keeps the block busy after the accepting edge, in these steps:
//   grid coordinate of three axes through the multiplier
//   eight corner reads from the single-port grid memory
//   14 products and 7 blend steps through the multiplier
//   load of the output register
// and no new word is taken until the sample is through. The result
// sits in an output register; req.ready returns while it waits, and a
// stalled receiver only holds the sequencer in its last step when a second
// result is ready. Configuration registers are written on cfg_we.
// Reset clears the sequencer and the output valid and loads the register
// defaults (origin 0, inverse spacing 1.0); grid cells are undefined until
// written.
// ----------------------------------------------------------------------------
module trilinear_grid_sampler #(
	parameter int unsigned XRES = tgs_pkg::TGS_XRES,
	parameter int unsigned YRES = tgs_pkg::TGS_YRES,
	parameter int unsigned ZRES = tgs_pkg::TGS_ZRES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tgs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tgs_pkg::VAL_W-1:0]         cfg_data,
	tgs_req_if.sink                           req,
	tgs_rsp_if.source                         rsp
);
	import tgs_pkg::*;

	localparam int unsigned XY_RES  = XRES * YRES;
	localparam int unsigned MAX_XY  = (XRES > YRES) ? XRES : YRES;
	localparam int unsigned MAX_RES = (MAX_XY > ZRES) ? MAX_XY : ZRES;
	localparam int unsigned IW      = $clog2(MAX_RES);
	localparam logic [CIDX_W-1:0] XM1 = CIDX_W'(XRES - 1);
	localparam logic [CIDX_W-1:0] YM1 = CIDX_W'(YRES - 1);
	localparam logic [CIDX_W-1:0] ZM1 = CIDX_W'(ZRES - 1);
	localparam int unsigned NVAL    = 15;

	typedef enum logic [2:0] {S_IDLE, S_AXIS, S_READ, S_BLEND, S_OUT} state_t;

	function automatic logic [CIDX_W-1:0] clamp_idx(input logic signed [CIDX_W-1:0] v,
		input logic [CIDX_W-1:0] hi);
		logic [CIDX_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed(hi)) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	state_t                    state_q;
	logic [3:0]                cnt_q;
	logic signed [VAL_W-1:0]   origin_q [3];
	logic [INV_W-1:0]          inv_q [3];
	logic                      rsp_valid_q;

	logic signed [VAL_W-1:0]   pos_q [3];
	logic [IW-1:0]             lo_q [3];
	logic [IW-1:0]             hi_q [3];
	logic signed [WGT_W-1:0]   w1_q [3];
	logic signed [VAL_W-1:0]   v_q [NVAL];
	logic signed [ACC_W-1:0]   acc_q;
	logic                      sat_q;
	logic signed [VAL_W-1:0]   rsp_value_q;
	logic                      rsp_sat_q;

	logic                      accept;
	logic                      out_free;
	logic [1:0]                ax_issue;
	logic [1:0]                ax_post;
	logic [3:0]                jpost;
	logic [3:0]                vdst;
	logic signed [DIFF_W-1:0]  mul_a;
	logic signed [MULB_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [WGT_W-1:0]   wsel1;
	logic signed [WGT_W-1:0]   wsel;
	logic signed [PROD_W-1:0]  g_full;
	logic signed [COORD_W-1:0] g_c;
	logic signed [COORD_W-1:0] neg_g;
	logic signed [CIDX_W-1:0]  i0_n;
	logic [CIDX_W-1:0]         res_m1;
	logic [CIDX_W-1:0]         lo_w;
	logic [CIDX_W-1:0]         hi_w;
	logic signed [WGT_W-1:0]   w1_n;
	logic signed [ACC_W-1:0]   sum_n;
	logic signed [ACC_W-1:0]   rnd_n;
	logic signed [VAL_W-1:0]   blend_n;
	logic                      blend_sat;
	logic [2:0]                corner;
	logic [IW-1:0]             cx;
	logic [IW-1:0]             cy;
	logic [IW-1:0]             cz;
	mem_req_t                  mreq;
	logic [VAL_W-1:0]          mem_rdata;

	assign req.ready        = (state_q == S_IDLE);
	assign accept           = req.valid && req.ready;
	assign out_free         = !rsp_valid_q || rsp.ready;
	assign rsp.valid        = rsp_valid_q;
	assign rsp.sample_value = rsp_value_q;
	assign rsp.saturated    = rsp_sat_q;

	assign ax_issue = (cnt_q < 4'd3) ? cnt_q[1:0] : 2'd0;
	assign ax_post  = cnt_q[1:0] - 2'd1;
	assign jpost    = cnt_q - 4'd1;
	assign vdst     = 4'd8 + {1'b0, jpost[3:1]};

	// operand select for the shared multiplier
	always_comb begin
		if (cnt_q[3:1] < 3'd4) begin
			wsel1 = w1_q[1];
		end else if (cnt_q[3:1] < 3'd6) begin
			wsel1 = w1_q[0];
		end else begin
			wsel1 = w1_q[2];
		end
		wsel = cnt_q[0] ? wsel1 : ($signed(WGT_ONE) - wsel1);
		if (state_q == S_BLEND) begin
			mul_a = {{(DIFF_W-WGT_W){wsel[WGT_W-1]}}, wsel};
			mul_b = (cnt_q < 4'(NVAL)) ? v_q[cnt_q] : v_q[0];
		end else begin
			mul_a = {pos_q[ax_issue][VAL_W-1], pos_q[ax_issue]}
				- {origin_q[ax_issue][VAL_W-1], origin_q[ax_issue]};
			mul_b = {1'b0, inv_q[ax_issue]};
		end
	end

	tgs_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// grid coordinate, corner indices and upper weight of one axis
	always_comb begin
		unique case (ax_post)
			2'd0:    res_m1 = XM1;
			2'd1:    res_m1 = YM1;
			default: res_m1 = ZM1;
		endcase
		g_full = prod >>> FRAC_W;
		if (g_full > COORD_LIMIT) begin
			g_c = COORD_LIMIT;
		end else if (g_full < -COORD_LIMIT) begin
			g_c = -COORD_LIMIT;
		end else begin
			g_c = COORD_W'(g_full);
		end
		neg_g = -g_c;
		if (g_c[COORD_W-1]) begin
			i0_n = CIDX_W'(0) - $signed(neg_g[COORD_W-1:FRAC_W]);
		end else begin
			i0_n = $signed(g_c[COORD_W-1:FRAC_W]);
		end
		lo_w = clamp_idx(i0_n, res_m1);
		hi_w = clamp_idx(i0_n + 14'sd1, res_m1);
		w1_n = $signed({g_c[COORD_W-1], g_c})
			- $signed({{(WGT_W-FRAC_W-IW){1'b0}}, lo_w[IW-1:0], {FRAC_W{1'b0}}});
	end

	// blend step: round, shift and clip the sum of two products
	always_comb begin
		sum_n = acc_q + {prod[PROD_W-1], prod};
		rnd_n = sum_n >>> FRAC_W;
		if (rnd_n[ACC_W-1:VAL_W-1] == '0 || rnd_n[ACC_W-1:VAL_W-1] == '1) begin
			blend_n   = VAL_W'(rnd_n);
			blend_sat = 1'b0;
		end else begin
			blend_n   = rnd_n[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
			blend_sat = 1'b1;
		end
	end

	// corner address: bit 2 selects z, bit 1 x, bit 0 y
	always_comb begin
		corner = cnt_q[2:0];
		cx = corner[1] ? hi_q[0] : lo_q[0];
		cy = corner[0] ? hi_q[1] : lo_q[1];
		cz = corner[2] ? hi_q[2] : lo_q[2];
		if (state_q == S_IDLE) begin
			mreq.we    = accept && (req.op == OP_WRITE);
			mreq.addr  = req.cell_index;
			mreq.wdata = req.cell_value;
		end else begin
			mreq.we    = 1'b0;
			mreq.addr  = ADDR_W'(cx) + ADDR_W'(32'(cy) * XRES) + ADDR_W'(32'(cz) * XY_RES);
			mreq.wdata = req.cell_value;
		end
	end

	tgs_mem u_mem (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				origin_q[i] <= '0;
				inv_q[i]    <= INV_W'(65536);
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ORIGIN_X: origin_q[0] <= cfg_data;
					REG_ORIGIN_Y: origin_q[1] <= cfg_data;
					REG_ORIGIN_Z: origin_q[2] <= cfg_data;
					REG_INV_DX:   inv_q[0]    <= cfg_data[INV_W-1:0];
					REG_INV_DY:   inv_q[1]    <= cfg_data[INV_W-1:0];
					REG_INV_DZ:   inv_q[2]    <= cfg_data[INV_W-1:0];
					default:      ;
				endcase
			end
			if (rsp.ready && state_q != S_OUT) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && req.op == OP_SAMPLE) begin
						state_q <= S_AXIS;
						cnt_q   <= '0;
					end
				end
				S_AXIS: begin
					if (cnt_q == 4'd3) begin
						state_q <= S_READ;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_READ: begin
					if (cnt_q == 4'd8) begin
						state_q <= S_BLEND;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_BLEND: begin
					if (cnt_q == 4'd14) begin
						state_q <= S_OUT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_OUT: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.op == OP_SAMPLE) begin
			pos_q[0] <= req.pos_x;
			pos_q[1] <= req.pos_y;
			pos_q[2] <= req.pos_z;
			sat_q    <= 1'b0;
		end
		if (state_q == S_AXIS && cnt_q != 4'd0) begin
			lo_q[ax_post] <= lo_w[IW-1:0];
			hi_q[ax_post] <= hi_w[IW-1:0];
			w1_q[ax_post] <= w1_n;
		end
		if (state_q == S_READ && cnt_q != 4'd0) begin
			v_q[jpost] <= mem_rdata;
		end
		if (state_q == S_BLEND && cnt_q != 4'd0) begin
			if (!jpost[0]) begin
				acc_q <= {prod[PROD_W-1], prod} + ROUND_HALF;
			end else begin
				v_q[vdst] <= blend_n;
				sat_q     <= sat_q | blend_sat;
			end
		end
		if (state_q == S_OUT && out_free) begin
			rsp_value_q <= v_q[NVAL-1];
			rsp_sat_q   <= sat_q;
		end
	end

endmodule

>>> hdl/tgs_checker.sv
// ----------------------------------------------------------------------------
// tgs_checker
// Port-level checks of the sampler, bound to the top level.
// ----------------------------------------------------------------------------
module tgs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        req_op,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [tgs_pkg::VAL_W-1:0]   rsp_sample_value,
	input logic                        rsp_saturated
);
	import tgs_pkg::*;

	// a sample word occupies the sequencer
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_op == OP_SAMPLE |=> !req_ready)
		else $error("ready held after a sample word");

	// a write word completes in its own cycle
	a_write_fast: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_op == OP_WRITE |=> req_ready)
		else $error("ready dropped after a write word");

	// a write word never produces a result word
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_op == OP_WRITE && !rsp_valid |=> !rsp_valid)
		else $error("result word after a write word");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
			rsp_valid && $stable(rsp_sample_value) && $stable(rsp_saturated))
		else $error("stalled result word changed");

endmodule

bind trilinear_grid_sampler tgs_checker u_tgs_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_op           (req.op),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_sample_value (rsp.sample_value),
	.rsp_saturated    (rsp.saturated)
);

>>> sim/trilinear_grid_sampler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trilinear_grid_sampler_tb
// Self-checking bench for the trilinear grid sampler. Loads grid cells and
// samples positions under several grid settings, with extremes and zero inverse
// spacing. Predicts every sample word in step with the accepted request
// stream and checks value and saturation flag. Both channels idle at random.
// ----------------------------------------------------------------------------
module trilinear_grid_sampler_tb;
	import tgs_pkg::*;

	typedef struct {
		logic                    op;
		logic [ADDR_W-1:0]       cell_index;
		logic signed [VAL_W-1:0] cell_value;
		logic signed [VAL_W-1:0] pos_x;
		logic signed [VAL_W-1:0] pos_y;
		logic signed [VAL_W-1:0] pos_z;
	} req_word_t;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic                    sat;
	} sample_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VAL_W-1:0]     cfg_data;

	tgs_req_if req_ch ();
	tgs_rsp_if rsp_ch ();

	trilinear_grid_sampler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// grid image and register copies used for prediction
	logic signed [VAL_W-1:0] grid_mem [GRID_DEPTH];
	logic signed [VAL_W-1:0] origin_q [3] = '{0, 0, 0};
	logic [INV_W-1:0]        inv_q [3]    = '{65536, 65536, 65536};

	bit                      cell_loaded [GRID_DEPTH];
	req_word_t               req_words [$];
	sample_word_t            sample_due [$];
	int unsigned             words_loaded = 0;
	int unsigned             words_sent = 0;
	int unsigned             results_seen = 0;
	int unsigned             error_count = 0;
	bit                      req_fire = 1'b0;

	bit                      send_idle_on = 1'b1;
	int unsigned             send_gap = 0;
	bit                      recv_idle_on = 1'b1;
	int unsigned             recv_hold = 0;
	bit                      long_hold_done = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned idle_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	function automatic void grid_axis(input logic signed [VAL_W-1:0] pos,
			input logic signed [VAL_W-1:0] org, input logic [INV_W-1:0] inv,
			input int res, output int lo, output int hi, output longint w1);
		longint g;
		longint i0;
		g = ((longint'(pos) - longint'(org)) * longint'(inv)) >>> 16;
		if (g > 268435456)
			g = 268435456;
		if (g < -268435456)
			g = -268435456;
		i0 = (g >= 0) ? (g >>> 16) : -((-g) >>> 16);
		lo = (i0 < 0) ? 0 : (i0 > res - 1) ? res - 1 : int'(i0);
		hi = (i0 + 1 < 0) ? 0 : (i0 + 1 > res - 1) ? res - 1 : int'(i0 + 1);
		w1 = g - longint'(lo) * 65536;
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input int x, input int y, input int z);
		return ADDR_W'(x + y * TGS_XRES + z * TGS_XRES * TGS_YRES);
	endfunction

	function automatic longint cell_at(input int x, input int y, input int z);
		return longint'(grid_mem[cell_addr(x, y, z)]);
	endfunction

	function automatic longint blend(input longint w1, input longint a, input longint b,
			inout bit sat);
		longint r;
		r = ((65536 - w1) * a + w1 * b + 32768) >>> 16;
		if (r > 64'sd2147483647) begin
			r = 64'sd2147483647;
			sat = 1'b1;
		end
		if (r < -64'sd2147483648) begin
			r = -64'sd2147483648;
			sat = 1'b1;
		end
		return r;
	endfunction

	function automatic sample_word_t interpolate(input logic signed [VAL_W-1:0] px,
			input logic signed [VAL_W-1:0] py, input logic signed [VAL_W-1:0] pz);
		int x0, x1, y0, y1, z0, z1;
		longint s, t, u, a00, a10, a01, a11, b0, b1, r;
		bit sat;
		sample_word_t w;
		sat = 1'b0;
		grid_axis(px, origin_q[0], inv_q[0], TGS_XRES, x0, x1, s);
		grid_axis(py, origin_q[1], inv_q[1], TGS_YRES, y0, y1, t);
		grid_axis(pz, origin_q[2], inv_q[2], TGS_ZRES, z0, z1, u);
		a00 = blend(t, cell_at(x0, y0, z0), cell_at(x0, y1, z0), sat);
		a10 = blend(t, cell_at(x1, y0, z0), cell_at(x1, y1, z0), sat);
		a01 = blend(t, cell_at(x0, y0, z1), cell_at(x0, y1, z1), sat);
		a11 = blend(t, cell_at(x1, y0, z1), cell_at(x1, y1, z1), sat);
		b0 = blend(s, a00, a10, sat);
		b1 = blend(s, a01, a11, sat);
		r = blend(u, b0, b1, sat);
		w.value = r[VAL_W-1:0];
		w.sat = sat;
		return w;
	endfunction

	function automatic logic signed [VAL_W-1:0] cell_word();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			return $urandom;
		if (pick < 70)
			return $urandom_range(0, 20 << 16) - (10 << 16);
		if (pick < 85) begin
			case ($urandom_range(0, 3))
				0: return 32'h7fffffff;
				1: return 32'h80000000;
				2: return 32'h0;
				default: return 32'hffffffff;
			endcase
		end
		return {($urandom_range(0, 1) != 0) ? 2'b01 : 2'b10, 30'($urandom)};
	endfunction

	// pick a position that lands mostly in or near the grid
	function automatic logic signed [VAL_W-1:0] aim_axis(input logic signed [VAL_W-1:0] org,
			input logic [INV_W-1:0] inv, input int unsigned res);
		int unsigned pick;
		longint g;
		longint p;
		pick = $urandom_range(0, 99);
		if (pick < 10 || inv == 0)
			return $urandom;
		if (pick < 18) begin
			case ($urandom_range(0, 3))
				0: return 32'h7fffffff;
				1: return 32'h80000000;
				2: return 32'h0;
				default: return org;
			endcase
		end
		if (pick < 30)
			g = (longint'($urandom_range(0, res)) - 1) * 65536;
		else
			g = longint'($urandom_range(0, (res + 3) * 65536)) - 2 * 65536;
		p = longint'(org) + (g * 65536) / longint'(inv);
		if (p > 64'sd2147483647)
			p = 64'sd2147483647;
		if (p < -64'sd2147483648)
			p = -64'sd2147483648;
		return p[VAL_W-1:0];
	endfunction

	task automatic queue_word(input req_word_t word);
		req_words.push_back(word);
		words_loaded++;
	endtask

	task automatic load_cell(input logic [ADDR_W-1:0] idx, input logic signed [VAL_W-1:0] val);
		req_word_t word;
		word.op = OP_WRITE;
		word.cell_index = idx;
		word.cell_value = val;
		word.pos_x = $urandom;
		word.pos_y = $urandom;
		word.pos_z = $urandom;
		cell_loaded[idx] = 1'b1;
		queue_word(word);
	endtask

	// write any corner not yet loaded, then queue the sample
	task automatic sample_at(input logic signed [VAL_W-1:0] px,
			input logic signed [VAL_W-1:0] py, input logic signed [VAL_W-1:0] pz);
		int x[2], y[2], z[2];
		longint w;
		logic [ADDR_W-1:0] addr;
		req_word_t word;
		grid_axis(px, origin_q[0], inv_q[0], TGS_XRES, x[0], x[1], w);
		grid_axis(py, origin_q[1], inv_q[1], TGS_YRES, y[0], y[1], w);
		grid_axis(pz, origin_q[2], inv_q[2], TGS_ZRES, z[0], z[1], w);
		for (int i = 0; i < 8; i++) begin
			addr = cell_addr(x[i & 1], y[(i >> 1) & 1], z[(i >> 2) & 1]);
			if (!cell_loaded[addr])
				load_cell(addr, cell_word());
		end
		word.op = OP_SAMPLE;
		word.cell_index = ADDR_W'($urandom);
		word.cell_value = $urandom;
		word.pos_x = px;
		word.pos_y = py;
		word.pos_z = pz;
		queue_word(word);
	endtask

	task automatic load_batch(input int unsigned count);
		int unsigned start;
		start = words_loaded;
		while (words_loaded - start < count) begin
			if ($urandom_range(0, 99) < 35)
				load_cell(ADDR_W'($urandom), cell_word());
			else
				sample_at(aim_axis(origin_q[0], inv_q[0], TGS_XRES),
					aim_axis(origin_q[1], inv_q[1], TGS_YRES),
					aim_axis(origin_q[2], inv_q[2], TGS_ZRES));
		end
	endtask

	task automatic drain_block();
		do
			@(negedge clk);
		while (words_sent != words_loaded || sample_due.size() != 0);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_grid(input logic [VAL_W-1:0] ox, input logic [VAL_W-1:0] oy,
			input logic [VAL_W-1:0] oz, input logic [VAL_W-1:0] ix,
			input logic [VAL_W-1:0] iy, input logic [VAL_W-1:0] iz);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ORIGIN_Z, oz);
		write_reg(REG_INV_DX, ix);
		write_reg(REG_INV_DY, iy);
		write_reg(REG_INV_DZ, iz);
	endtask

	// request driver
	always @(negedge clk) begin : drive_req
		req_word_t word;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (req_ch.valid && !req_fire) begin
			// hold until taken
		end else if (send_gap != 0) begin
			send_gap <= send_gap - 1;
			req_ch.valid <= 1'b0;
		end else if (req_words.size() != 0) begin
			word = req_words.pop_front();
			req_ch.valid <= 1'b1;
			req_ch.op <= word.op;
			req_ch.cell_index <= word.cell_index;
			req_ch.cell_value <= word.cell_value;
			req_ch.pos_x <= word.pos_x;
			req_ch.pos_y <= word.pos_y;
			req_ch.pos_z <= word.pos_z;
			if (send_idle_on && $urandom_range(0, 3) == 0)
				send_gap <= idle_len();
			if ($urandom_range(0, 149) == 0)
				send_idle_on <= !send_idle_on;
		end else begin
			req_ch.valid <= 1'b0;
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (recv_hold != 0) begin
			recv_hold <= recv_hold - 1;
			rsp_ch.ready <= 1'b0;
		end else if (!long_hold_done && results_seen >= 30) begin
			long_hold_done <= 1'b1;
			recv_hold <= 600;
			rsp_ch.ready <= 1'b0;
		end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
			recv_hold <= idle_len();
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
		if ($urandom_range(0, 199) == 0)
			recv_idle_on <= !recv_idle_on;
	end

	// monitor: register copies, checks, prediction
	always @(posedge clk) begin : watch
		sample_word_t want;
		req_fire <= arst_n && req_ch.valid && req_ch.ready;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ORIGIN_X: origin_q[0] = cfg_data;
					REG_ORIGIN_Y: origin_q[1] = cfg_data;
					REG_ORIGIN_Z: origin_q[2] = cfg_data;
					REG_INV_DX:   inv_q[0] = cfg_data[INV_W-1:0];
					REG_INV_DY:   inv_q[1] = cfg_data[INV_W-1:0];
					REG_INV_DZ:   inv_q[2] = cfg_data[INV_W-1:0];
					default: ;
				endcase
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (sample_due.size() == 0) begin
					$error("sample word with none due: sample_value %0d",
						rsp_ch.sample_value);
					error_count++;
				end else begin
					want = sample_due.pop_front();
					if (rsp_ch.sample_value !== want.value) begin
						$error("sample_value: expected %0d, got %0d", want.value,
							rsp_ch.sample_value);
						error_count++;
					end
					if (rsp_ch.saturated !== want.sat) begin
						$error("saturated: expected %0b, got %0b", want.sat,
							rsp_ch.saturated);
						error_count++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				words_sent++;
				if (req_ch.op == OP_WRITE)
					grid_mem[req_ch.cell_index] = req_ch.cell_value;
				else
					sample_due.push_back(interpolate(req_ch.pos_x, req_ch.pos_y,
						req_ch.pos_z));
			end
		end
	end

	initial begin
		#60_000_000;
		$display("trilinear_grid_sampler_tb: done, errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_WRITE;
		req_ch.cell_index = '0;
		req_ch.cell_value = '0;
		req_ch.pos_x = '0;
		req_ch.pos_y = '0;
		req_ch.pos_z = '0;
		rsp_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// extremes at the default grid, unit spacing
		load_cell(0, 32'h7fffffff);
		load_cell('1, 32'h80000000);
		load_cell(1, 32'h80000000);
		load_cell(32, 32'h7fffffff);
		load_cell(1024, 32'h0);
		sample_at(0, 0, 0);
		sample_at(32768, 0, 0);
		sample_at(32768, 32768, 32768);
		sample_at(31 << 16, 31 << 16, 31 << 16);
		sample_at(-32768, -32768, -32768);
		sample_at(40 << 16, 16384, (31 << 16) + 49152);
		sample_at(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		sample_at(32'h80000000, 32'h80000000, 32'h80000000);
		sample_at(32'h7fffffff, 32'h80000000, 65536);
		load_batch(230);
		drain_block();

		set_grid(-32'sd229376, 32'sd147456, 32'sd655360, 131072, 32768, 65536);
		load_batch(230);
		drain_block();

		// extreme origins, narrowest and widest spacing, zero inverse spacing
		set_grid(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 1, 0);
		sample_at(32'h7fffffff, 32'h80000000, 32'h12345678);
		load_batch(120);
		drain_block();

		set_grid(32'h80000000, 32'h7fffffff, $urandom, 0, 32'h7fffffff, 1);
		load_batch(100);
		drain_block();

		set_grid($urandom_range(0, 128 << 16) - (64 << 16),
			$urandom_range(0, 128 << 16) - (64 << 16),
			$urandom_range(0, 128 << 16) - (64 << 16),
			$urandom_range(4096, 262144), $urandom_range(4096, 262144),
			$urandom_range(4096, 262144));
		load_batch(150);
		drain_block();
		load_batch(150);
		drain_block();

		set_grid(0, 0, 0, 65536, 65536, 65536);
		load_batch(230);
		drain_block();

		if (error_count == 0)
			$display("trilinear_grid_sampler_tb: done, clean");
		else
			$display("trilinear_grid_sampler_tb: done, errors");
		$finish;
	end

endmodule
